>>> src/stwt_pkg.sv
// Package for the synapse trace and weight table: sizes, codes, entry record,
// the exponential decay ROM and the structs passed between the table modules.
// Has no dependencies.
package stwt_pkg;

   localparam int TABLE_DEPTH       = 256;
   localparam int AVOIDANCE_CODE    = 1;
   localparam int DECAY_TABLE_DEPTH = 1024;

   localparam int ADDR_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int ROM_AW    = $clog2(DECAY_TABLE_DEPTH);

   localparam logic [15:0] TRACE_ONE        = 16'd32768;
   localparam logic [15:0] TRACE_MIN_ACTIVE = 16'd3277;
   localparam logic [15:0] STRENGTH_STEP    = 16'd3277;
   localparam logic [15:0] SAT16            = 16'hFFFF;
   localparam logic [63:0] EXP_STEP_Q32     = 64'd4252231657;

   typedef enum logic [2:0] {
      KIND_REGISTER   = 3'd0,
      KIND_UNREGISTER = 3'd1,
      KIND_SPIKE      = 3'd2,
      KIND_AVOID      = 3'd3,
      KIND_RELIEF     = 3'd4,
      KIND_DECAY      = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_WEIGHT_FLOOR   = 2'd0,
      CSR_WEIGHT_CEILING = 2'd1,
      CSR_AVOID_GAIN     = 2'd2,
      CSR_RELIEF_GAIN    = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REG,
      ST_SCAN,
      ST_UNREG_RD,
      ST_UNREG_WR,
      ST_SPIKE_WR,
      ST_WALK,
      ST_DRAIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [31:0] id;
      logic [2:0]  stype;
      logic [15:0] weight;
      logic [15:0] trace;
      logic [15:0] strength;
      logic [15:0] success;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         rec;
   } wr_type;

   // Operands that stay fixed while a table-wide update walks the entries.
   typedef struct packed {
      kind_type    op;
      logic [15:0] floor;
      logic [15:0] ceiling;
      logic [15:0] avoid_gain;
      logic [15:0] relief_gain;
      logic [15:0] relief_amount;
      logic [15:0] factor;
   } walk_ctx_type;

   typedef logic [15:0] decay_rom_type [DECAY_TABLE_DEPTH];

   // Entry k is exp(-k/100) in Q1.15, built by repeated rounded scaling in Q0.32.
   function automatic decay_rom_type build_decay_rom();
      decay_rom_type rom;
      logic [63:0]   v;
      logic [63:0]   p;
      v = 64'd1 << 32;
      for (int k = 0; k < DECAY_TABLE_DEPTH; k++) begin
         p = v + (64'd1 << 16);
         rom[k] = p[32:17];
         p = v * EXP_STEP_Q32 + (64'd1 << 31);
         v = {32'd0, p[63:32]};
      end
      return rom;
   endfunction

   localparam decay_rom_type DECAY_ROM = build_decay_rom();

endpackage

>>> src/stwt_entry_mem.sv
// Synchronous entry memory of the synapse table: one write and one read port,
// read data registered. Depends on stwt_pkg.
module stwt_entry_mem (
   input  logic                       clock,
   input  logic                       we,
   input  logic [stwt_pkg::ADDR_W-1:0] waddr,
   input  stwt_pkg::entry_type        wdata,
   input  logic [stwt_pkg::ADDR_W-1:0] raddr,
   output stwt_pkg::entry_type        rdata
);

   stwt_pkg::entry_type mem [stwt_pkg::TABLE_DEPTH];
   stwt_pkg::entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/stwt_walk_pipe.sv
// Read-modify-write pipeline for the table-wide updates (avoidance, relief,
// decay): multiply, second multiply, then round, clamp and write back.
// Depends on stwt_pkg.
module stwt_walk_pipe (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [stwt_pkg::ADDR_W-1:0] in_addr,
   input  stwt_pkg::entry_type         in_rec,
   input  stwt_pkg::walk_ctx_type      ctx,
   output stwt_pkg::wr_type            wr,
   output logic                        busy
);

   logic                        s2_v_ff, s3_v_ff;
   logic [stwt_pkg::ADDR_W-1:0] s2_addr_ff, s3_addr_ff;
   stwt_pkg::entry_type         s2_rec_ff, s3_rec_ff;
   logic                        s2_act_ff, s3_act_ff;
   logic [31:0]                 s2_m1_ff;
   logic [47:0]                 s3_m2_ff;

   logic [15:0] opnd;
   logic        act_in;
   logic [31:0] m1_in;
   logic [47:0] m2_in;

   logic [48:0] rnd;
   logic [17:0] boost;
   logic [18:0] wsum;
   logic [15:0] wclamp;
   logic [16:0] ssum;
   stwt_pkg::entry_type new_rec;

   // Stage one: trace times the per-operation factor.
   always_comb begin
      opnd   = ctx.factor;
      act_in = 1'b1;
      unique case (ctx.op)
         stwt_pkg::KIND_AVOID: begin
            opnd   = ctx.avoid_gain;
            act_in = (in_rec.trace >= stwt_pkg::TRACE_MIN_ACTIVE) &&
                     (in_rec.stype == 3'(stwt_pkg::AVOIDANCE_CODE));
         end
         stwt_pkg::KIND_RELIEF: begin
            opnd   = ctx.relief_amount;
            act_in = in_rec.trace >= stwt_pkg::TRACE_MIN_ACTIVE;
         end
         default: begin
            opnd   = ctx.factor;
            act_in = 1'b1;
         end
      endcase
      m1_in = in_rec.trace * opnd;
   end

   // Stage two: relief also scales by its gain.
   always_comb begin
      if (ctx.op == stwt_pkg::KIND_RELIEF) begin
         m2_in = s2_m1_ff * ctx.relief_gain;
      end else begin
         m2_in = {16'd0, s2_m1_ff};
      end
   end

   // Stage three: round, clamp and form the written entry.
   always_comb begin
      new_rec = s3_rec_ff;
      rnd     = {1'b0, s3_m2_ff} + 49'd32768;
      boost   = rnd[33:16];
      if (ctx.op == stwt_pkg::KIND_RELIEF) begin
         rnd   = {1'b0, s3_m2_ff} + (49'd1 << 30);
         boost = rnd[48:31];
      end else if (ctx.op == stwt_pkg::KIND_DECAY) begin
         rnd   = {1'b0, s3_m2_ff} + 49'd16384;
         boost = rnd[33:16];
      end
      wsum = 19'(s3_rec_ff.weight) + 19'(boost);
      if (wsum < 19'(ctx.floor)) begin
         wclamp = ctx.floor;
      end else if (wsum > 19'(ctx.ceiling)) begin
         wclamp = ctx.ceiling;
      end else begin
         wclamp = wsum[15:0];
      end
      ssum = 17'(s3_rec_ff.strength) + 17'(stwt_pkg::STRENGTH_STEP);
      if (ctx.op == stwt_pkg::KIND_DECAY) begin
         new_rec.trace = rnd[30:15];
      end else if (s3_act_ff) begin
         new_rec.weight = wclamp;
         if (ctx.op == stwt_pkg::KIND_AVOID) begin
            new_rec.strength = ssum[16] ? stwt_pkg::SAT16 : ssum[15:0];
            if (s3_rec_ff.success != stwt_pkg::SAT16) begin
               new_rec.success = s3_rec_ff.success + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= in_valid;
         s3_v_ff <= s2_v_ff;
      end
      s2_addr_ff <= in_addr;
      s2_rec_ff  <= in_rec;
      s2_act_ff  <= act_in;
      s2_m1_ff   <= m1_in;
      s3_addr_ff <= s2_addr_ff;
      s3_rec_ff  <= s2_rec_ff;
      s3_act_ff  <= s2_act_ff;
      s3_m2_ff   <= m2_in;
   end

   assign wr.en   = s3_v_ff;
   assign wr.addr = s3_addr_ff;
   assign wr.rec  = new_rec;
   assign busy    = s2_v_ff || s3_v_ff;

endmodule

>>> src/synapse_trace_weight_table.sv
// Top level of the synapse trace and weight table: sequencer, configuration
// registers and result register. Depends on stwt_pkg, stwt_entry_mem and stwt_walk_pipe.
//
// One request is handled at a time. Unregister and pre-spike scan the ids one per cycle;
// avoidance, relief and decay stream every entry through a read-modify-write pipeline.
// The entry memory has a single read port, visited one entry per cycle. A new request
// is taken while the previous result still waits in the output register. No clearing
// pass is needed after reset.
module synapse_trace_weight_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: synapse_key[31:0], synapse_type[34:32], seed_weight[50:35],
   // relief_amount[66:51], elapsed_ms[76:67], zero fill[79:77]
   input  logic [79:0] req_tdata,
   // tuser: kind[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: status[1:0], entry_weight[17:2], entry_trace[33:18],
   // entry_count[42:34], zero fill[47:43]
   output logic [47:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int AW = stwt_pkg::ADDR_W;
   localparam int CW = stwt_pkg::CNT_W;

   stwt_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          iss_ff, iss_in;
   logic [AW-1:0] iss_addr_ff;
   logic [AW-1:0] slot_ff, slot_in;
   stwt_pkg::entry_type rec_ff, rec_in;

   stwt_pkg::kind_type op_ff;
   logic [31:0] id_ff;
   logic [2:0]  type_ff;
   logic [15:0] w0_ff;
   logic [15:0] rel_ff;
   logic [15:0] factor_ff;

   logic [15:0] floor_ff, ceiling_ff, avoid_gain_ff, relief_gain_ff;

   stwt_pkg::status_type res_status_ff, res_status_in;
   logic [15:0] res_weight_ff, res_weight_in;
   logic [15:0] res_trace_ff, res_trace_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;

   logic                mem_we;
   logic [AW-1:0]       mem_waddr, mem_raddr;
   stwt_pkg::entry_type mem_wdata, mem_rdata;

   stwt_pkg::walk_ctx_type ctx;
   stwt_pkg::wr_type       walk_wr;
   logic                   walk_busy;
   logic                   accept;
   logic                   hit;
   logic [CW-1:0]          last;
   logic [stwt_pkg::ROM_AW-1:0] rom_idx;

   assign accept = req_tvalid && req_tready;
   assign hit    = iss_ff && (mem_rdata.id == id_ff);
   assign last   = count_ff - CW'(1);
   assign rom_idx = (32'(req_tdata[76:67]) >= 32'(stwt_pkg::DECAY_TABLE_DEPTH)) ?
                    stwt_pkg::ROM_AW'(stwt_pkg::DECAY_TABLE_DEPTH - 1) :
                    stwt_pkg::ROM_AW'(req_tdata[76:67]);

   assign ctx.op            = op_ff;
   assign ctx.floor         = floor_ff;
   assign ctx.ceiling       = ceiling_ff;
   assign ctx.avoid_gain    = avoid_gain_ff;
   assign ctx.relief_gain   = relief_gain_ff;
   assign ctx.relief_amount = rel_ff;
   assign ctx.factor        = factor_ff;

   stwt_entry_mem u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   stwt_walk_pipe u_walk (
      .clock    (clock),
      .reset    (reset),
      .in_valid (iss_ff && (state_ff == stwt_pkg::ST_WALK || state_ff == stwt_pkg::ST_DRAIN)),
      .in_addr  (iss_addr_ff),
      .in_rec   (mem_rdata),
      .ctx      (ctx),
      .wr       (walk_wr),
      .busy     (walk_busy)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      iss_in        = 1'b0;
      slot_in       = slot_ff;
      rec_in        = rec_ff;
      res_status_in = res_status_ff;
      res_weight_in = res_weight_ff;
      res_trace_in  = res_trace_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      req_tready    = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = slot_ff;
      mem_wdata     = rec_ff;
      mem_raddr     = idx_ff[AW-1:0];

      unique case (state_ff)
         stwt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               idx_in        = '0;
               res_status_in = stwt_pkg::STATUS_OK;
               res_weight_in = '0;
               res_trace_in  = '0;
               unique case (req_tuser)
                  stwt_pkg::KIND_REGISTER:   state_in = stwt_pkg::ST_REG;
                  stwt_pkg::KIND_UNREGISTER: state_in = stwt_pkg::ST_SCAN;
                  stwt_pkg::KIND_SPIKE:      state_in = stwt_pkg::ST_SCAN;
                  stwt_pkg::KIND_AVOID:      state_in = stwt_pkg::ST_WALK;
                  stwt_pkg::KIND_RELIEF:     state_in = stwt_pkg::ST_WALK;
                  stwt_pkg::KIND_DECAY:      state_in = stwt_pkg::ST_WALK;
                  default:                   state_in = stwt_pkg::ST_RESP;
               endcase
            end
         end
         stwt_pkg::ST_REG: begin
            if (32'(count_ff) >= 32'(stwt_pkg::TABLE_DEPTH)) begin
               res_status_in = stwt_pkg::STATUS_FULL;
            end else begin
               mem_we          = 1'b1;
               mem_waddr       = count_ff[AW-1:0];
               mem_wdata       = '0;
               mem_wdata.id    = id_ff;
               mem_wdata.stype = type_ff;
               mem_wdata.weight = w0_ff;
               count_in        = count_ff + CW'(1);
               res_weight_in   = w0_ff;
            end
            state_in = stwt_pkg::ST_RESP;
         end
         stwt_pkg::ST_SCAN: begin
            if (hit) begin
               slot_in  = iss_addr_ff;
               rec_in   = mem_rdata;
               state_in = (op_ff == stwt_pkg::KIND_UNREGISTER) ?
                          stwt_pkg::ST_UNREG_RD : stwt_pkg::ST_SPIKE_WR;
            end else if (idx_ff < count_ff) begin
               iss_in = 1'b1;
               idx_in = idx_ff + CW'(1);
            end else if (!iss_ff) begin
               res_status_in = stwt_pkg::STATUS_NOT_FOUND;
               state_in      = stwt_pkg::ST_RESP;
            end
         end
         stwt_pkg::ST_UNREG_RD: begin
            mem_raddr = last[AW-1:0];
            state_in  = stwt_pkg::ST_UNREG_WR;
         end
         stwt_pkg::ST_UNREG_WR: begin
            // The last entry moves into the freed slot.
            mem_we    = 1'b1;
            mem_waddr = slot_ff;
            mem_wdata = mem_rdata;
            count_in  = last;
            state_in  = stwt_pkg::ST_RESP;
         end
         stwt_pkg::ST_SPIKE_WR: begin
            mem_we          = 1'b1;
            mem_waddr       = slot_ff;
            mem_wdata       = rec_ff;
            mem_wdata.trace = stwt_pkg::TRACE_ONE;
            res_weight_in   = rec_ff.weight;
            res_trace_in    = stwt_pkg::TRACE_ONE;
            state_in        = stwt_pkg::ST_RESP;
         end
         stwt_pkg::ST_WALK: begin
            if (idx_ff < count_ff) begin
               iss_in = 1'b1;
               idx_in = idx_ff + CW'(1);
            end else begin
               state_in = stwt_pkg::ST_DRAIN;
            end
         end
         stwt_pkg::ST_DRAIN: begin
            if (!iss_ff && !walk_busy) begin
               state_in = stwt_pkg::ST_RESP;
            end
         end
         stwt_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, 9'(count_ff), res_trace_ff, res_weight_ff,
                               res_status_ff};
               state_in     = stwt_pkg::ST_IDLE;
            end
         end
         default: state_in = stwt_pkg::ST_IDLE;
      endcase

      // Write-backs of the update pipeline never meet another write.
      if (walk_wr.en) begin
         mem_we    = 1'b1;
         mem_waddr = walk_wr.addr;
         mem_wdata = walk_wr.rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= stwt_pkg::ST_IDLE;
         count_ff       <= '0;
         iss_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         floor_ff       <= 16'd0;
         ceiling_ff     <= 16'd32768;
         avoid_gain_ff  <= 16'd1311;
         relief_gain_ff <= 16'd983;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_ff       <= iss_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (stwt_pkg::csr_index_type'(csr_addr))
               stwt_pkg::CSR_WEIGHT_FLOOR:   floor_ff       <= csr_wdata;
               stwt_pkg::CSR_WEIGHT_CEILING: ceiling_ff     <= csr_wdata;
               stwt_pkg::CSR_AVOID_GAIN:     avoid_gain_ff  <= csr_wdata;
               stwt_pkg::CSR_RELIEF_GAIN:    relief_gain_ff <= csr_wdata;
               default:                      floor_ff       <= floor_ff;
            endcase
         end
      end
      idx_ff        <= idx_in;
      iss_addr_ff   <= idx_ff[AW-1:0];
      slot_ff       <= slot_in;
      rec_ff        <= rec_in;
      res_status_ff <= res_status_in;
      res_weight_ff <= res_weight_in;
      res_trace_ff  <= res_trace_in;
      rsp_data_ff   <= rsp_data_in;
      if (accept) begin
         op_ff     <= stwt_pkg::kind_type'(req_tuser);
         id_ff     <= req_tdata[31:0];
         type_ff   <= req_tdata[34:32];
         w0_ff     <= req_tdata[50:35];
         rel_ff    <= req_tdata[66:51];
         factor_ff <= stwt_pkg::DECAY_ROM[rom_idx];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> bench/testbench.sv
// Self-checking bench for synapse_trace_weight_table: directed and random requests
// go through the request stream, and every response is checked against a local predictor.
// Depends on stwt_pkg and the synapse_trace_weight_table RTL.
module testbench;
   import stwt_pkg::*;

   localparam int DEPTH = 256;
   localparam int IDLE_LIMIT = 6000;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] weight;
      logic [15:0] trace;
      logic [8:0]  count;
   } rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   synapse_trace_weight_table uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state: the synapse table, its fill level and the settings.
   logic [31:0] syn_id [DEPTH];
   logic [2:0]  syn_type [DEPTH];
   logic [15:0] syn_weight [DEPTH];
   logic [15:0] syn_trace [DEPTH];
   logic [15:0] syn_strength [DEPTH];
   logic [15:0] syn_success [DEPTH];
   int          syn_count;
   logic [15:0] floor_q, ceiling_q, avoid_gain_q, relief_gain_q;
   logic [15:0] exp_factor [1024];

   rsp_type     expected_rsp [$];
   logic [31:0] id_pool [16];
   int          errors = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   function automatic logic [15:0] clamp_weight(longint unsigned v);
      if (v < floor_q) return floor_q;
      if (v > ceiling_q) return ceiling_q;
      return v[15:0];
   endfunction

   function automatic int lookup_slot(logic [31:0] id);
      for (int i = 0; i < syn_count; i++)
         if (syn_id[i] == id) return i;
      return -1;
   endfunction

   function automatic rsp_type apply_request(logic [2:0] kind, logic [31:0] id,
                                             logic [2:0] typ, logic [15:0] w0,
                                             logic [15:0] rel, logic [9:0] ms);
      rsp_type r;
      int s;
      longint unsigned p;
      r = '0;
      if (kind == KIND_REGISTER) begin
         if (syn_count >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            syn_id[syn_count] = id;
            syn_type[syn_count] = typ;
            syn_weight[syn_count] = w0;
            syn_trace[syn_count] = '0;
            syn_strength[syn_count] = '0;
            syn_success[syn_count] = '0;
            syn_count++;
            r.weight = w0;
         end
      end else if (kind == KIND_UNREGISTER || kind == KIND_SPIKE) begin
         s = lookup_slot(id);
         if (s < 0) begin
            r.status = STATUS_NOT_FOUND;
         end else if (kind == KIND_UNREGISTER) begin
            syn_id[s] = syn_id[syn_count-1];
            syn_type[s] = syn_type[syn_count-1];
            syn_weight[s] = syn_weight[syn_count-1];
            syn_trace[s] = syn_trace[syn_count-1];
            syn_strength[s] = syn_strength[syn_count-1];
            syn_success[s] = syn_success[syn_count-1];
            syn_count--;
         end else begin
            syn_trace[s] = TRACE_ONE;
            r.weight = syn_weight[s];
            r.trace = TRACE_ONE;
         end
      end else if (kind == KIND_AVOID) begin
         for (int i = 0; i < syn_count; i++)
            if (syn_type[i] == AVOIDANCE_CODE && syn_trace[i] >= TRACE_MIN_ACTIVE) begin
               p = (longint'(syn_trace[i]) * avoid_gain_q + 32768) >> 16;
               syn_weight[i] = clamp_weight(syn_weight[i] + p);
               p = longint'(syn_strength[i]) + STRENGTH_STEP;
               syn_strength[i] = (p > 65535) ? 16'hFFFF : p[15:0];
               if (syn_success[i] != 16'hFFFF) syn_success[i]++;
            end
      end else if (kind == KIND_RELIEF) begin
         for (int i = 0; i < syn_count; i++)
            if (syn_trace[i] >= TRACE_MIN_ACTIVE) begin
               p = longint'(syn_trace[i]) * rel * relief_gain_q;
               p = (p + (64'd1 << 30)) >> 31;
               syn_weight[i] = clamp_weight(syn_weight[i] + p);
            end
      end else if (kind == KIND_DECAY) begin
         for (int i = 0; i < syn_count; i++) begin
            p = (longint'(syn_trace[i]) * exp_factor[ms] + 16384) >> 15;
            syn_trace[i] = p[15:0];
         end
      end
      r.count = syn_count[8:0];
      return r;
   endfunction

   task automatic send_request(logic [2:0] kind, logic [31:0] id, logic [2:0] typ,
                               logic [15:0] w0, logic [15:0] rel, logic [9:0] ms);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = {3'b000, ms, rel, w0, typ, id};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_rsp.push_back(apply_request(kind, id, typ, w0, rel, ms));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Settings change only once the table has gone quiet.
   task automatic write_setting(csr_index_type idx, logic [15:0] value);
      req_tvalid = 1'b0;
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (syn_count + 12) @(negedge clock);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_WEIGHT_FLOOR:   floor_q = value;
         CSR_WEIGHT_CEILING: ceiling_q = value;
         CSR_AVOID_GAIN:     avoid_gain_q = value;
         default:            relief_gain_q = value;
      endcase
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      rsp_type got, want;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{status: rsp_tdata[1:0], weight: rsp_tdata[17:2],
                 trace: rsp_tdata[33:18], count: rsp_tdata[42:34]};
         if (expected_rsp.size() == 0) begin
            errors++;
            $display("%0t: response expected none actual %h", $time, got);
         end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status) begin
               errors++;
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            end
            if (got.weight !== want.weight) begin
               errors++;
               $display("%0t: weight expected %0d actual %0d", $time, want.weight, got.weight);
            end
            if (got.trace !== want.trace) begin
               errors++;
               $display("%0t: trace expected %0d actual %0d", $time, want.trace, got.trace);
            end
            if (got.count !== want.count) begin
               errors++;
               $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
            end
         end
      end
   end

   task automatic test_directed_kinds();
      send_request(KIND_SPIKE, 32'h1234, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_UNREGISTER, 32'h1234, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_REGISTER, 32'h0, 3'd1, 16'd32768, 16'd0, 10'd0);
      send_request(KIND_REGISTER, 32'hFFFF_FFFF, 3'd7, 16'd0, 16'd0, 10'd0);
      send_request(KIND_REGISTER, 32'hA5A5_5A5A, 3'd1, 16'd1000, 16'd0, 10'd0);
      // Same id twice: lookups must land on the lower slot.
      send_request(KIND_REGISTER, 32'hA5A5_5A5A, 3'd1, 16'd2000, 16'd0, 10'd0);
      send_request(KIND_SPIKE, 32'hA5A5_5A5A, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_SPIKE, 32'h0, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_SPIKE, 32'hFFFF_FFFF, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_AVOID, 32'h0, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_RELIEF, 32'h0, 3'd0, 16'd0, 16'd32768, 10'd0);
      send_request(KIND_DECAY, 32'h0, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_DECAY, 32'h0, 3'd0, 16'd0, 16'd0, 10'd230);
      send_request(KIND_RELIEF, 32'h0, 3'd0, 16'd0, 16'd32768, 10'd0);
      send_request(KIND_DECAY, 32'h0, 3'd0, 16'd0, 16'd0, 10'd1023);
      send_request(3'd6, 32'h0, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(3'd7, 32'hFFFF_FFFF, 3'd7, 16'hFFFF, 16'hFFFF, 10'h3FF);
      send_request(KIND_UNREGISTER, 32'h0, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_UNREGISTER, 32'hA5A5_5A5A, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_SPIKE, 32'hA5A5_5A5A, 3'd0, 16'd0, 16'd0, 10'd0);
   endtask

   task automatic test_clamp_bounds();
      write_setting(CSR_AVOID_GAIN, 16'hFFFF);
      write_setting(CSR_RELIEF_GAIN, 16'hFFFF);
      send_request(KIND_SPIKE, 32'hFFFF_FFFF, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_SPIKE, 32'hA5A5_5A5A, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_AVOID, 32'h0, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_RELIEF, 32'h0, 3'd0, 16'd0, 16'd32768, 10'd0);
      // Floor above ceiling: anything under the floor lands on it, the rest on the ceiling.
      write_setting(CSR_WEIGHT_FLOOR, 16'd30000);
      write_setting(CSR_WEIGHT_CEILING, 16'd1000);
      send_request(KIND_REGISTER, 32'h77, 3'd1, 16'd5, 16'd0, 10'd0);
      send_request(KIND_SPIKE, 32'h77, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_AVOID, 32'h0, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_RELIEF, 32'h0, 3'd0, 16'd0, 16'd100, 10'd0);
      write_setting(CSR_WEIGHT_FLOOR, 16'd32768);
      write_setting(CSR_WEIGHT_CEILING, 16'd32768);
      send_request(KIND_AVOID, 32'h0, 3'd0, 16'd0, 16'd0, 10'd0);
      write_setting(CSR_WEIGHT_FLOOR, 16'd0);
      write_setting(CSR_AVOID_GAIN, 16'd0);
      write_setting(CSR_RELIEF_GAIN, 16'd0);
      send_request(KIND_RELIEF, 32'h0, 3'd0, 16'd0, 16'd32768, 10'd0);
      send_request(KIND_AVOID, 32'h0, 3'd0, 16'd0, 16'd0, 10'd0);
   endtask

   task automatic test_full_table();
      write_setting(CSR_AVOID_GAIN, 16'd1311);
      write_setting(CSR_RELIEF_GAIN, 16'd983);
      while (syn_count < DEPTH)
         send_request(KIND_REGISTER, $urandom, 3'($urandom_range(1, 0)),
                      16'($urandom_range(32768)), 16'd0, 10'd0);
      send_request(KIND_REGISTER, 32'hDEAD, 3'd1, 16'd9, 16'd0, 10'd0);
      send_request(KIND_SPIKE, syn_id[DEPTH-1], 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_SPIKE, syn_id[5], 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_AVOID, 32'h0, 3'd0, 16'd0, 16'd0, 10'd0);
      send_request(KIND_RELIEF, 32'h0, 3'd0, 16'd0, 16'd20000, 10'd0);
      send_request(KIND_DECAY, 32'h0, 3'd0, 16'd0, 16'd0, 10'd3);
      while (syn_count > 4)
         send_request(KIND_UNREGISTER, syn_id[$urandom_range(syn_count - 1)],
                      3'd0, 16'd0, 16'd0, 10'd0);
   endtask

   // Mostly lookups on live ids, with triggers and short decays so traces stay active.
   task automatic test_random_traffic(int items);
      logic [2:0]  kind;
      logic [31:0] id;
      logic [15:0] w0, rel;
      logic [9:0]  ms;
      int pick;
      for (int n = 0; n < items; n++) begin
         pick = $urandom_range(99);
         if (pick < 22) kind = (syn_count < 40) ? KIND_REGISTER : KIND_UNREGISTER;
         else if (pick < 32) kind = (syn_count > 8) ? KIND_UNREGISTER : KIND_REGISTER;
         else if (pick < 55) kind = KIND_SPIKE;
         else if (pick < 70) kind = KIND_AVOID;
         else if (pick < 82) kind = KIND_RELIEF;
         else if (pick < 97) kind = KIND_DECAY;
         else kind = 3'($urandom_range(7, 6));
         if ($urandom_range(9) == 0) id = $urandom;
         else if (kind != KIND_REGISTER && syn_count > 0 && $urandom_range(3) != 0)
            id = syn_id[$urandom_range(syn_count - 1)];
         else id = id_pool[$urandom_range(15)];
         w0 = ($urandom_range(15) == 0) ? 16'd32768 : 16'($urandom_range(32767));
         rel = ($urandom_range(15) == 0) ? 16'd32768 : 16'($urandom_range(32767));
         ms = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(40));
         send_request(kind, id, ($urandom_range(2) == 0) ? 3'd1 : 3'($urandom),
                      w0, rel, ms);
      end
   endtask

   task automatic random_settings();
      write_setting(CSR_WEIGHT_FLOOR, 16'($urandom_range(8000)));
      write_setting(CSR_WEIGHT_CEILING, 16'($urandom_range(32768, 16000)));
      write_setting(CSR_AVOID_GAIN, 16'($urandom));
      write_setting(CSR_RELIEF_GAIN, 16'($urandom));
   endtask

   initial begin
      longint unsigned v;
      v = 64'd1 << 32;
      for (int k = 0; k < 1024; k++) begin
         exp_factor[k] = 16'((v + (64'd1 << 16)) >> 17);
         v = (v * 64'd4252231657 + (64'd1 << 31)) >> 32;
      end
      for (int i = 0; i < 16; i++) id_pool[i] = (i < 8) ? 32'(i) : $urandom;
      syn_count = 0;
      floor_q = 16'd0;
      ceiling_q = 16'd32768;
      avoid_gain_q = 16'd1311;
      relief_gain_q = 16'd983;
      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed_kinds();
      test_clamp_bounds();
      test_full_table();

      send_idle_pct = 36;
      recv_idle_pct = 87;
      random_settings();
      test_random_traffic(120);
      send_idle_pct = 87;
      recv_idle_pct = 36;
      write_setting(CSR_WEIGHT_FLOOR, 16'd0);
      write_setting(CSR_WEIGHT_CEILING, 16'd32768);
      write_setting(CSR_AVOID_GAIN, 16'hFFFF);
      write_setting(CSR_RELIEF_GAIN, 16'hFFFF);
      test_random_traffic(120);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_settings();
      test_random_traffic(120);

      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule

>>> sim.f
src/stwt_pkg.sv
src/stwt_entry_mem.sv
src/stwt_walk_pipe.sv
src/synapse_trace_weight_table.sv
bench/testbench.sv
